>>> hdl/ebpf_alu_branch_execute_top_assert.svh
// Assertion macros shared by the eBPF execute unit.
// Expects a clock i_clk and an active-low reset i_rst_n in the using module.
`ifndef EBPF_ALU_BRANCH_EXECUTE_TOP_ASSERT_SVH
`define EBPF_ALU_BRANCH_EXECUTE_TOP_ASSERT_SVH

// The consequent holds in the same cycle as the antecedent.
`define EBPF_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define EBPF_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hdl/ebpf_pkg.sv
// Shared types, opcodes and codes for the eBPF execute unit.
// No dependencies.
package ebpf_pkg;

    localparam int REG_COUNT_DEF = 11;

    // Exact opcodes.
    localparam logic [7:0] OP_LDDW = 8'h18;
    localparam logic [7:0] OP_CALL = 8'h85;
    localparam logic [7:0] OP_EXIT = 8'h95;

    // Instruction classes.
    localparam logic [2:0] CLS_ALU32 = 3'd4;
    localparam logic [2:0] CLS_JMP   = 3'd5;
    localparam logic [2:0] CLS_ALU64 = 3'd7;

    // ALU operations.
    localparam logic [3:0] ALU_ADD  = 4'h0;
    localparam logic [3:0] ALU_SUB  = 4'h1;
    localparam logic [3:0] ALU_MUL  = 4'h2;
    localparam logic [3:0] ALU_DIV  = 4'h3;
    localparam logic [3:0] ALU_OR   = 4'h4;
    localparam logic [3:0] ALU_AND  = 4'h5;
    localparam logic [3:0] ALU_LSH  = 4'h6;
    localparam logic [3:0] ALU_RSH  = 4'h7;
    localparam logic [3:0] ALU_NEG  = 4'h8;
    localparam logic [3:0] ALU_MOD  = 4'h9;
    localparam logic [3:0] ALU_XOR  = 4'ha;
    localparam logic [3:0] ALU_MOV  = 4'hb;
    localparam logic [3:0] ALU_ARSH = 4'hc;

    // Jump operations.
    localparam logic [3:0] JMP_JA   = 4'h0;
    localparam logic [3:0] JMP_JEQ  = 4'h1;
    localparam logic [3:0] JMP_JGT  = 4'h2;
    localparam logic [3:0] JMP_JGE  = 4'h3;
    localparam logic [3:0] JMP_JSET = 4'h4;
    localparam logic [3:0] JMP_JNE  = 4'h5;
    localparam logic [3:0] JMP_JSGT = 4'h6;
    localparam logic [3:0] JMP_JSGE = 4'h7;
    localparam logic [3:0] JMP_JLT  = 4'ha;
    localparam logic [3:0] JMP_JLE  = 4'hb;
    localparam logic [3:0] JMP_JSLT = 4'hc;
    localparam logic [3:0] JMP_JSLE = 4'hd;

    // Result status codes.
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_ILLEGAL = 2'd1;
    localparam logic [1:0] ST_BADCALL = 2'd2;
    localparam logic [1:0] ST_EXIT    = 2'd3;

    // Configuration register indexes.
    localparam logic [1:0] CFG_CONTEXT = 2'd0;
    localparam logic [1:0] CFG_STACK   = 2'd1;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;
        logic exec;
        logic md_start;
        logic wr_top;
        logic md_wb;
        logic load_out;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic is_start;
        logic need_md;
        logic md_done;
    } t_sts;

endpackage

>>> hdl/ebpf_muldiv.sv
// Shared iterative unit: shift-and-add multiply and restoring divide, one bit a cycle.
// Depends on nothing but its ports.
module ebpf_muldiv (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic        i_is_div,
    input  logic [63:0] i_a,
    input  logic [63:0] i_b,
    output logic        o_done,
    output logic [63:0] o_prod,
    output logic [63:0] o_quot,
    output logic [63:0] o_rem
);
    localparam logic [5:0] LAST = 6'd63;

    logic        r_busy, r_done, r_div, r_bz;
    logic [5:0]  r_cnt;
    logic [64:0] r_acc;
    logic [63:0] r_x, r_y;
    logic [64:0] rem_sh, rem_sub;

    // One restoring step: shift in the next dividend bit and try the subtract.
    assign rem_sh  = {r_acc[63:0], r_x[63]};
    assign rem_sub = rem_sh - {1'b0, r_y};

    // Sequencing of the 64 steps.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 6'd1;
                if (r_cnt == LAST) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Operand and accumulator registers.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_acc <= '0;
            r_x   <= i_a;
            r_y   <= i_b;
            r_div <= i_is_div;
            r_bz  <= (i_b == 64'd0);
        end else if (r_busy) begin
            if (r_div) begin
                if (!rem_sub[64]) begin
                    r_acc <= rem_sub;
                    r_x   <= {r_x[62:0], 1'b1};
                end else begin
                    r_acc <= rem_sh;
                    r_x   <= {r_x[62:0], 1'b0};
                end
            end else begin
                r_acc <= {1'b0, r_acc[63:0] + (r_y[0] ? r_x : 64'd0)};
                r_x   <= {r_x[62:0], 1'b0};
                r_y   <= {1'b0, r_y[63:1]};
            end
        end
    end

    assign o_done = r_done;
    assign o_prod = r_acc[63:0];
    assign o_rem  = r_acc[63:0];
    // A zero divisor gives a zero quotient.
    assign o_quot = r_bz ? 64'd0 : r_x;

endmodule

>>> hdl/ebpf_ctrl.sv
// Controller state machine of the eBPF execute unit.
// Depends on ebpf_pkg and the assertion header.
`include "ebpf_alu_branch_execute_top_assert.svh"
module ebpf_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_stall,
    output logic            o_out_valid,
    input  logic            i_out_stall,
    input  ebpf_pkg::t_sts  i_sts,
    output ebpf_pkg::t_cmd  o_cmd
);
    import ebpf_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_EXEC   = 5'b00010,
        S_START2 = 5'b00100,
        S_MULDIV = 5'b01000,
        S_FINISH = 5'b10000
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   out_free;

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign out_free    = !r_out_valid || !i_out_stall;

    // Next state and commands.
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = S_EXEC;
                end
            end
            S_EXEC: begin
                o_cmd.exec = 1'b1;
                if (i_sts.is_start) begin
                    n_state = S_START2;
                end else if (i_sts.need_md) begin
                    o_cmd.md_start = 1'b1;
                    n_state        = S_MULDIV;
                end else begin
                    n_state = S_FINISH;
                end
            end
            S_START2: begin
                o_cmd.wr_top = 1'b1;
                n_state      = S_FINISH;
            end
            S_MULDIV: begin
                if (i_sts.md_done) begin
                    o_cmd.md_wb = 1'b1;
                    n_state     = S_FINISH;
                end
            end
            S_FINISH: begin
                if (out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // The output word stays until the receiver takes it.
    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.load_out) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    `EBPF_ASSERT_NEXT(a_accept_exec, o_cmd.accept, r_state == S_EXEC, "accept must go to execute")
    `EBPF_ASSERT_NEXT(a_load_valid, o_cmd.load_out, r_out_valid, "loaded word must be valid")
    `EBPF_ASSERT_SAME(a_load_free, o_cmd.load_out, out_free, "output overwritten while held")

endmodule

>>> hdl/ebpf_dpath.sv
// Datapath of the eBPF execute unit: register file, ALU, branch compare, result registers.
// Depends on ebpf_pkg and ebpf_muldiv.
module ebpf_dpath #(
    parameter int REG_COUNT = ebpf_pkg::REG_COUNT_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  ebpf_pkg::t_cmd     i_cmd,
    output ebpf_pkg::t_sts     o_sts,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_index,
    input  logic [63:0]        i_cfg_data,
    input  logic               i_command,
    input  logic [7:0]         i_opcode,
    input  logic [3:0]         i_dest_index,
    input  logic [3:0]         i_source_index,
    input  logic signed [15:0] i_branch_offset,
    input  logic signed [31:0] i_immediate,
    input  logic [31:0]        i_immediate_next,
    output logic [1:0]         o_status,
    output logic               o_branch_taken,
    output logic signed [16:0] o_pc_step,
    output logic [63:0]        o_return_value
);
    import ebpf_pkg::*;

    localparam int AW = $clog2(REG_COUNT);
    localparam logic [4:0] IDX_LIMIT = 5'(REG_COUNT);
    localparam logic [AW-1:0] IDX_CTX = AW'(1);
    localparam logic [AW-1:0] IDX_FP  = AW'(10);
    localparam logic [AW-1:0] IDX_R0  = AW'(0);

    // Configuration registers.
    logic [63:0] r_ctx, r_stack;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctx   <= '0;
            r_stack <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_CONTEXT: r_ctx   <= i_cfg_data;
                CFG_STACK:   r_stack <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Captured input word.
    logic               r_cmd;
    logic [7:0]         r_opc;
    logic [3:0]         r_di, r_si;
    logic signed [15:0] r_off;
    logic signed [31:0] r_imm;
    logic [31:0]        r_immn;
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_cmd  <= i_command;
            r_opc  <= i_opcode;
            r_di   <= i_dest_index;
            r_si   <= i_source_index;
            r_off  <= i_branch_offset;
            r_imm  <= i_immediate;
            r_immn <= i_immediate_next;
        end
    end

    // Register file with per-entry valid bits and a copy of r0.
    logic [63:0]     r_mem [REG_COUNT];
    logic            r_vld [REG_COUNT];
    logic [63:0]     r_r0;
    logic [63:0]     r_rd_d, r_rd_s;
    logic            r_rd_d_v, r_rd_s_v;
    logic            in_d_ok, in_s_ok;
    logic [AW-1:0]   ra_d, ra_s;
    logic            we;
    logic [AW-1:0]   waddr;
    logic [63:0]     wdata;

    assign in_d_ok = ({1'b0, i_dest_index} < IDX_LIMIT);
    assign in_s_ok = ({1'b0, i_source_index} < IDX_LIMIT);
    assign ra_d    = in_d_ok ? i_dest_index[AW-1:0] : '0;
    assign ra_s    = in_s_ok ? i_source_index[AW-1:0] : '0;

    // Registered reads at accept.
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_rd_d   <= r_mem[ra_d];
            r_rd_s   <= r_mem[ra_s];
            r_rd_d_v <= in_d_ok && r_vld[ra_d];
            r_rd_s_v <= in_s_ok && r_vld[ra_s];
        end
    end

    // Single write port.
    always_ff @(posedge i_clk) begin
        if (we) begin
            r_mem[waddr] <= wdata;
        end
    end

    // Valid bits and r0 copy; a start command clears the file.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < REG_COUNT; k++) begin
                r_vld[k] <= 1'b0;
            end
            r_r0 <= '0;
        end else if (i_cmd.accept && i_command) begin
            for (int k = 0; k < REG_COUNT; k++) begin
                r_vld[k] <= 1'b0;
            end
            r_r0 <= '0;
        end else if (we) begin
            r_vld[waddr] <= 1'b1;
            if (waddr == IDX_R0) begin
                r_r0 <= wdata;
            end
        end
    end

    // Operand preparation.
    logic [2:0]  cls;
    logic [3:0]  op;
    logic        xsrc, wide;
    logic [63:0] d_val, s_val, imm64, src, mask, dm, sm;
    logic [5:0]  sh_n;
    logic        di_bad, si_bad;

    assign cls    = r_opc[2:0];
    assign op     = r_opc[7:4];
    assign xsrc   = r_opc[3];
    assign wide   = (cls == CLS_ALU64);
    assign d_val  = r_rd_d_v ? r_rd_d : 64'd0;
    assign s_val  = r_rd_s_v ? r_rd_s : 64'd0;
    assign imm64  = {{32{r_imm[31]}}, r_imm};
    assign src    = xsrc ? s_val : imm64;
    assign mask   = wide ? {64{1'b1}} : {32'd0, {32{1'b1}}};
    assign dm     = d_val & mask;
    assign sm     = src & mask;
    assign sh_n   = wide ? sm[5:0] : {1'b0, sm[4:0]};
    assign di_bad = ({1'b0, r_di} >= IDX_LIMIT);
    assign si_bad = ({1'b0, r_si} >= IDX_LIMIT);

    // Combinational ALU operations; multiply, divide and modulo go to the shared unit.
    logic [63:0]        alu_r;
    logic               alu_ok, alu_md;
    logic signed [31:0] d32;
    logic signed [31:0] ars32;
    logic signed [63:0] ars64;

    assign d32   = dm[31:0];
    assign ars32 = d32 >>> sh_n[4:0];
    assign ars64 = $signed(dm) >>> sh_n;

    always_comb begin
        alu_ok = 1'b1;
        alu_md = 1'b0;
        alu_r  = dm;
        unique case (op)
            ALU_ADD:  alu_r = dm + sm;
            ALU_SUB:  alu_r = dm - sm;
            ALU_OR:   alu_r = dm | sm;
            ALU_AND:  alu_r = dm & sm;
            ALU_LSH:  alu_r = dm << sh_n;
            ALU_RSH:  alu_r = dm >> sh_n;
            ALU_NEG:  alu_r = 64'd0 - dm;
            ALU_XOR:  alu_r = dm ^ sm;
            ALU_MOV:  alu_r = sm;
            ALU_ARSH: alu_r = wide ? 64'(ars64) : {32'd0, 32'(ars32)};
            ALU_MUL, ALU_DIV, ALU_MOD: alu_md = 1'b1;
            default:  alu_ok = 1'b0;
        endcase
    end

    // Branch conditions on full 64-bit operands.
    logic cond, cond_ok;
    always_comb begin
        cond_ok = 1'b1;
        cond    = 1'b0;
        unique case (op)
            JMP_JA:   cond = 1'b1;
            JMP_JEQ:  cond = (d_val == src);
            JMP_JGT:  cond = (d_val > src);
            JMP_JGE:  cond = (d_val >= src);
            JMP_JSET: cond = |(d_val & src);
            JMP_JNE:  cond = (d_val != src);
            JMP_JSGT: cond = ($signed(d_val) > $signed(src));
            JMP_JSGE: cond = ($signed(d_val) >= $signed(src));
            JMP_JLT:  cond = (d_val < src);
            JMP_JLE:  cond = (d_val <= src);
            JMP_JSLT: cond = ($signed(d_val) < $signed(src));
            JMP_JSLE: cond = ($signed(d_val) <= $signed(src));
            default:  cond_ok = 1'b0;
        endcase
    end

    // Instruction decision.
    logic [1:0]         e_status;
    logic               e_taken, e_we, e_md;
    logic signed [16:0] e_step;
    logic [63:0]        e_wdata;
    logic               needs_src;

    assign needs_src = xsrc && (op != ALU_NEG);

    always_comb begin
        e_status = ST_OK;
        e_taken  = 1'b0;
        e_step   = 17'sd1;
        e_we     = 1'b0;
        e_md     = 1'b0;
        e_wdata  = alu_r & mask;
        if (r_cmd) begin
            e_step  = 17'sd0;
            e_we    = 1'b1;
            e_wdata = r_ctx;
        end else if (r_opc == OP_CALL) begin
            e_status = ST_BADCALL;
        end else if (r_opc == OP_EXIT) begin
            e_status = ST_EXIT;
        end else if (cls == CLS_ALU64 || cls == CLS_ALU32) begin
            if (di_bad || (needs_src && si_bad) || !alu_ok) begin
                e_status = ST_ILLEGAL;
            end else if (alu_md) begin
                e_md = 1'b1;
            end else begin
                e_we = 1'b1;
            end
        end else if (cls == CLS_JMP) begin
            if ((op != JMP_JA && (di_bad || (xsrc && si_bad))) || !cond_ok) begin
                e_status = ST_ILLEGAL;
            end else if (cond) begin
                e_taken = 1'b1;
                e_step  = 17'sd1 + 17'(r_off);
            end
        end else if (r_opc == OP_LDDW && !di_bad) begin
            e_we    = 1'b1;
            e_wdata = {r_immn, r_imm};
            e_step  = 17'sd2;
        end else begin
            e_status = ST_ILLEGAL;
        end
        if (e_status != ST_OK) begin
            e_step = 17'sd0;
        end
    end

    // Multiply and divide unit.
    logic        md_done;
    logic [63:0] md_prod, md_quot, md_rem, md_res;

    ebpf_muldiv u_muldiv (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (i_cmd.md_start),
        .i_is_div (op != ALU_MUL),
        .i_a      (dm),
        .i_b      (sm),
        .o_done   (md_done),
        .o_prod   (md_prod),
        .o_quot   (md_quot),
        .o_rem    (md_rem)
    );

    always_comb begin
        case (op)
            ALU_MUL: md_res = md_prod & mask;
            ALU_DIV: md_res = md_quot & mask;
            default: md_res = md_rem & mask;
        endcase
    end

    // Write port selection.
    always_comb begin
        we    = 1'b0;
        waddr = r_di[AW-1:0];
        wdata = e_wdata;
        if (i_cmd.exec && e_we) begin
            we    = 1'b1;
            waddr = r_cmd ? IDX_CTX : r_di[AW-1:0];
        end else if (i_cmd.wr_top) begin
            we    = 1'b1;
            waddr = IDX_FP;
            wdata = r_stack;
        end else if (i_cmd.md_wb) begin
            we    = 1'b1;
            wdata = md_res;
        end
    end

    // Result registers, then the output word.
    logic [1:0]         r_status;
    logic               r_taken;
    logic signed [16:0] r_step;
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_status <= e_status;
            r_taken  <= e_taken;
            r_step   <= e_step;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            o_status       <= r_status;
            o_branch_taken <= r_taken;
            o_pc_step      <= r_step;
            o_return_value <= r_r0;
        end
    end

    assign o_sts.is_start = r_cmd;
    assign o_sts.need_md  = e_md;
    assign o_sts.md_done  = md_done;

endmodule

>>> hdl/ebpf_alu_branch_execute_top.sv
// Each word is accepted in idle, executed, then loaded into the output register once it is free;
// a start word also writes the stack address to r10. Multiply, divide and modulo wait for the
// shared unit, which does one bit per cycle. One word is in work at a time, and the next waits
// until the result is queued.
// Reset (synchronous, active low) clears the register file valid bits and config registers.
// Top level of the eBPF execute unit; depends on ebpf_pkg, ebpf_ctrl and ebpf_dpath.
module ebpf_alu_branch_execute_top #(
    parameter int REG_COUNT = ebpf_pkg::REG_COUNT_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [1:0]         i_cfg_index,
    input  logic [63:0]        i_cfg_data,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic               i_command,
    input  logic [7:0]         i_opcode,
    input  logic [3:0]         i_dest_index,
    input  logic [3:0]         i_source_index,
    input  logic signed [15:0] i_branch_offset,
    input  logic signed [31:0] i_immediate,
    input  logic [31:0]        i_immediate_next,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [1:0]         o_status,
    output logic               o_branch_taken,
    output logic signed [16:0] o_pc_step,
    output logic [63:0]        o_return_value
);
    import ebpf_pkg::*;

    t_cmd cmd;
    t_sts sts;

    assign o_cfg_ready = 1'b1;

    // Controller.
    ebpf_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    // Datapath.
    ebpf_dpath #(.REG_COUNT(REG_COUNT)) u_dpath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_sts            (sts),
        .i_cfg_we         (i_cfg_valid),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_command        (i_command),
        .i_opcode         (i_opcode),
        .i_dest_index     (i_dest_index),
        .i_source_index   (i_source_index),
        .i_branch_offset  (i_branch_offset),
        .i_immediate      (i_immediate),
        .i_immediate_next (i_immediate_next),
        .o_status         (o_status),
        .o_branch_taken   (o_branch_taken),
        .o_pc_step        (o_pc_step),
        .o_return_value   (o_return_value)
    );

endmodule

>>> tb/ebpf_alu_branch_execute_top_test.sv
`timescale 1ns / 100ps
// Self-checking testbench for the eBPF ALU and branch execute unit.
// Depends on ebpf_pkg and ebpf_alu_branch_execute_top; a software predictor checks each result.
module ebpf_alu_branch_execute_top_test;
    import ebpf_pkg::*;

    localparam int NREG = REG_COUNT_DEF;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int SETTLE_CYCLES = 80;

    typedef struct {
        logic        cmd;
        logic [7:0]  opc;
        logic [3:0]  di;
        logic [3:0]  si;
        logic [15:0] off;
        logic [31:0] imm;
        logic [31:0] immn;
    } insn_t;

    typedef struct {
        logic [1:0]  status;
        logic        taken;
        logic [16:0] step;
        logic [63:0] ret;
    } outcome_t;

    typedef struct {
        insn_t    insn;
        logic     typed;
        outcome_t want;
    } row_t;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_cfg_valid = 1'b0;
    logic               o_cfg_ready;
    logic [1:0]         i_cfg_index = '0;
    logic [63:0]        i_cfg_data = '0;
    logic               i_in_valid = 1'b0;
    logic               o_in_stall;
    logic               i_command = 1'b0;
    logic [7:0]         i_opcode = '0;
    logic [3:0]         i_dest_index = '0;
    logic [3:0]         i_source_index = '0;
    logic signed [15:0] i_branch_offset = '0;
    logic signed [31:0] i_immediate = '0;
    logic [31:0]        i_immediate_next = '0;
    logic               o_out_valid;
    logic               i_out_stall = 1'b0;
    logic [1:0]         o_status;
    logic               o_branch_taken;
    logic signed [16:0] o_pc_step;
    logic [63:0]        o_return_value;

    // Predictor state.
    logic [63:0] gpr [0:15];
    logic [63:0] ctx_addr;
    logic [63:0] stack_addr;

    outcome_t pending[$];
    int       errors = 0;
    int       cycles = 0;
    bit       quiet = 1'b0;
    int       stall_left = 0;
    row_t     plan [0:23];

    ebpf_alu_branch_execute_top u_dut (.*);

    always #4 i_clk = ~i_clk;

    // Cycle limit.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    function automatic logic [63:0] alu_calc(input logic [3:0] op, input logic [63:0] d_in,
                                             input logic [63:0] s_in, input logic wide,
                                             output logic ok);
        logic [63:0] mask, d, s, r;
        int n;
        mask = wide ? 64'hFFFF_FFFF_FFFF_FFFF : 64'h0000_0000_FFFF_FFFF;
        d = d_in & mask;
        s = s_in & mask;
        n = wide ? int'(s[5:0]) : int'(s[4:0]);
        ok = 1'b1;
        case (op)
            ALU_ADD: r = d + s;
            ALU_SUB: r = d - s;
            ALU_MUL: r = d * s;
            ALU_DIV: r = (s != 0) ? d / s : 64'd0;
            ALU_OR:  r = d | s;
            ALU_AND: r = d & s;
            ALU_LSH: r = d << n;
            ALU_RSH: r = d >> n;
            ALU_NEG: r = 64'd0 - d;
            ALU_MOD: r = (s != 0) ? d % s : d;
            ALU_XOR: r = d ^ s;
            ALU_MOV: r = s;
            ALU_ARSH: begin
                r = d >> n;
                if (wide ? d[63] : d[31])
                    r = r | (mask & ~(mask >> n));
            end
            default: begin
                ok = 1'b0;
                r = d;
            end
        endcase
        return r & mask;
    endfunction

    // Returns 1 for taken, 0 for not taken, -1 for an undefined jump.
    function automatic int jump_hit(input logic [3:0] op, input logic [63:0] d,
                                    input logic [63:0] s);
        case (op)
            JMP_JA:   return 1;
            JMP_JEQ:  return int'(d == s);
            JMP_JGT:  return int'(d > s);
            JMP_JGE:  return int'(d >= s);
            JMP_JSET: return int'((d & s) != 0);
            JMP_JNE:  return int'(d != s);
            JMP_JSGT: return int'($signed(d) > $signed(s));
            JMP_JSGE: return int'($signed(d) >= $signed(s));
            JMP_JLT:  return int'(d < s);
            JMP_JLE:  return int'(d <= s);
            JMP_JSLT: return int'($signed(d) < $signed(s));
            JMP_JSLE: return int'($signed(d) <= $signed(s));
            default:  return -1;
        endcase
    endfunction

    // Executes one instruction word on the predictor's register file.
    function automatic outcome_t exec_insn(input insn_t w);
        logic [2:0]  cls;
        logic [3:0]  op;
        logic        xsrc, ok;
        logic [63:0] imm64, s, d, r;
        int          c;
        outcome_t    o;
        cls = w.opc[2:0];
        op = w.opc[7:4];
        xsrc = w.opc[3];
        imm64 = {{32{w.imm[31]}}, w.imm};
        o.status = ST_OK;
        o.taken = 1'b0;
        o.step = 17'd1;
        if (w.cmd) begin
            for (int i = 0; i < 16; i++)
                gpr[i] = '0;
            gpr[1] = ctx_addr;
            gpr[10] = stack_addr;
            o.step = 17'd0;
        end else if (w.opc == OP_CALL) begin
            o.status = ST_BADCALL;
        end else if (w.opc == OP_EXIT) begin
            o.status = ST_EXIT;
        end else if (cls == CLS_ALU64 || cls == CLS_ALU32) begin
            if (w.di >= NREG || (xsrc && op != ALU_NEG && w.si >= NREG)) begin
                o.status = ST_ILLEGAL;
            end else begin
                s = xsrc ? ((w.si < NREG) ? gpr[w.si] : 64'd0) : imm64;
                r = alu_calc(op, gpr[w.di], s, cls == CLS_ALU64, ok);
                if (ok)
                    gpr[w.di] = r;
                else
                    o.status = ST_ILLEGAL;
            end
        end else if (cls == CLS_JMP) begin
            if (op != JMP_JA && (w.di >= NREG || (xsrc && w.si >= NREG))) begin
                o.status = ST_ILLEGAL;
            end else begin
                d = (w.di < NREG) ? gpr[w.di] : 64'd0;
                s = xsrc ? ((w.si < NREG) ? gpr[w.si] : 64'd0) : imm64;
                c = jump_hit(op, d, s);
                if (c < 0) begin
                    o.status = ST_ILLEGAL;
                end else if (c > 0) begin
                    o.taken = 1'b1;
                    o.step = 17'd1 + {w.off[15], w.off};
                end
            end
        end else if (w.opc == OP_LDDW && w.di < NREG) begin
            gpr[w.di] = {w.immn, w.imm};
            o.step = 17'd2;
        end else begin
            o.status = ST_ILLEGAL;
        end
        if (o.status != ST_OK)
            o.step = 17'd0;
        o.ret = gpr[0];
        return o;
    endfunction

    function automatic insn_t mk(input logic cmd, input logic [7:0] opc, input logic [3:0] di,
                                 input logic [3:0] si, input logic [15:0] off,
                                 input logic [31:0] imm, input logic [31:0] immn);
        insn_t w;
        w.cmd = cmd; w.opc = opc; w.di = di; w.si = si;
        w.off = off; w.imm = imm; w.immn = immn;
        return w;
    endfunction

    function automatic outcome_t res(input logic [1:0] st, input logic tk,
                                     input logic [16:0] stp, input logic [63:0] rv);
        outcome_t o;
        o.status = st; o.taken = tk; o.step = stp; o.ret = rv;
        return o;
    endfunction

    function automatic logic [3:0] pick_reg();
        return ($urandom_range(0, 15) < 14) ? 4'($urandom_range(0, 10)) :
                                              4'($urandom_range(11, 15));
    endfunction

    function automatic logic [31:0] pick_imm();
        case ($urandom_range(0, 7))
            0: return 32'($urandom_range(0, 3)) - 32'd1;
            1: return 32'h8000_0000;
            2: return 32'h7FFF_FFFF;
            3: return 32'($urandom_range(0, 70));
            default: return $urandom;
        endcase
    endfunction

    // Random instruction: mostly well-formed ALU, jump and wide loads, plus noise.
    function automatic insn_t rand_insn();
        insn_t w;
        int k;
        logic [3:0] op;
        w = mk(1'b0, 8'($urandom), pick_reg(), pick_reg(), 16'($urandom), pick_imm(), $urandom);
        k = $urandom_range(0, 99);
        if (k < 4) begin
            w.cmd = 1'b1;
        end else if (k < 10) begin
            w.opc = 8'($urandom);
        end else if (k < 13) begin
            w.opc = ($urandom_range(0, 1) != 0) ? OP_CALL : OP_EXIT;
        end else if (k < 25) begin
            w.opc = OP_LDDW;
        end else if (k < 65) begin
            op = ($urandom_range(0, 19) == 0) ? 4'($urandom_range(13, 15)) :
                                                4'($urandom_range(0, 12));
            w.opc = {op, 1'($urandom), ($urandom_range(0, 1) != 0) ? CLS_ALU64 : CLS_ALU32};
        end else begin
            op = ($urandom_range(0, 19) == 0) ? 4'($urandom) : 4'($urandom_range(0, 13));
            w.opc = {op, 1'($urandom), CLS_JMP};
        end
        return w;
    endfunction

    // Results: compare against the oldest expectation and drive random stalls.
    always @(posedge i_clk) begin
        outcome_t e;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending.size() == 0) begin
                $display("%0t: unexpected word status=%0d", $time, o_status);
                errors++;
            end else begin
                e = pending.pop_front();
                if (o_status !== e.status || o_branch_taken !== e.taken ||
                    o_pc_step !== e.step || o_return_value !== e.ret) begin
                    $display("%0t: mismatch expected st=%0d tk=%0d step=%0h ret=%h",
                             $time, e.status, e.taken, e.step, e.ret);
                    $display("%0t:          actual   st=%0d tk=%0d step=%0h ret=%h",
                             $time, o_status, o_branch_taken, o_pc_step, o_return_value);
                    errors++;
                end
            end
        end
        if (quiet || !i_rst_n) begin
            i_out_stall <= 1'b0;
        end else if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            i_out_stall <= 1'b1;
        end else if ($urandom_range(0, 15) == 0) begin
            stall_left <= $urandom_range(0, 11);
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    task automatic write_reg(input logic [1:0] idx, input logic [63:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (idx == CFG_CONTEXT)
            ctx_addr = val;
        else
            stack_addr = val;
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // Sends one word; the expectation is the typed one if given, else the predictor's.
    task automatic send_word(input insn_t w, input logic typed, input outcome_t want);
        outcome_t p;
        int gap;
        i_in_valid <= 1'b1;
        i_command <= w.cmd;
        i_opcode <= w.opc;
        i_dest_index <= w.di;
        i_source_index <= w.si;
        i_branch_offset <= w.off;
        i_immediate <= w.imm;
        i_immediate_next <= w.immn;
        do @(posedge i_clk); while (o_in_stall);
        p = exec_insn(w);
        pending.push_back(typed ? want : p);
        if (!quiet && $urandom_range(0, 7) == 0) begin
            gap = $urandom_range(1, 12);
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        while (pending.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    initial begin
        outcome_t none;
        none = res(ST_OK, 1'b0, 17'd0, 64'd0);
        for (int i = 0; i < 16; i++)
            gpr[i] = '0;
        ctx_addr = '0;
        stack_addr = '0;

        // Directed words: status codes, register limits, extremes and corner cases.
        plan[0]  = '{mk(1, 8'h00, 0, 0, 0, 0, 0), 1, none};
        plan[1]  = '{mk(0, OP_EXIT, 0, 0, 0, 0, 0), 1, res(ST_EXIT, 0, 0, 0)};
        plan[2]  = '{mk(0, OP_CALL, 0, 0, 0, 0, 0), 1, res(ST_BADCALL, 0, 0, 0)};
        plan[3]  = '{mk(0, 8'h61, 1, 2, 0, 0, 0), 1, res(ST_ILLEGAL, 0, 0, 0)};
        plan[4]  = '{mk(0, {ALU_MOV, 1'b0, CLS_ALU64}, 15, 0, 0, 1, 0), 1,
                     res(ST_ILLEGAL, 0, 0, 0)};
        plan[5]  = '{mk(0, {ALU_MOV, 1'b0, CLS_ALU64}, 0, 0, 0, 32'hFFFF_FFFF, 0), 1,
                     res(ST_OK, 0, 1, 64'hFFFF_FFFF_FFFF_FFFF)};
        plan[6]  = '{mk(0, {ALU_ADD, 1'b0, CLS_ALU32}, 0, 0, 0, 1, 0), 1, res(ST_OK, 0, 1, 0)};
        plan[7]  = '{mk(0, OP_LDDW, 0, 0, 0, 32'h8000_0000, 32'hFFFF_FFFF), 1,
                     res(ST_OK, 0, 2, 64'hFFFF_FFFF_8000_0000)};
        plan[8]  = '{mk(0, OP_LDDW, 11, 0, 0, 5, 5), 1,
                     res(ST_ILLEGAL, 0, 0, 64'hFFFF_FFFF_8000_0000)};
        // Division by a zero register clears r0.
        plan[9]  = '{mk(0, {ALU_DIV, 1'b1, CLS_ALU64}, 0, 2, 0, 0, 0), 1, res(ST_OK, 0, 1, 0)};
        plan[10] = '{mk(0, OP_LDDW, 3, 0, 0, 7, 32'h8000_0000), 0, none};
        plan[11] = '{mk(0, {ALU_MOD, 1'b1, CLS_ALU64}, 3, 2, 0, 0, 0), 0, none};
        plan[12] = '{mk(0, {ALU_MOD, 1'b0, CLS_ALU32}, 1, 0, 0, 0, 0), 0, none};
        plan[13] = '{mk(0, {ALU_LSH, 1'b0, CLS_ALU64}, 10, 0, 0, 32'h7F, 0), 0, none};
        plan[14] = '{mk(0, {ALU_ARSH, 1'b1, CLS_ALU64}, 3, 1, 0, 0, 0), 0, none};
        // Negate ignores an out-of-range source index.
        plan[15] = '{mk(0, {ALU_NEG, 1'b1, CLS_ALU64}, 3, 15, 0, 0, 0), 0, none};
        // Unconditional jump ignores both register indexes.
        plan[16] = '{mk(0, {JMP_JA, 1'b1, CLS_JMP}, 15, 15, 16'h8000, 0, 0), 1,
                     res(ST_OK, 1, 17'h18001, 0)};
        plan[17] = '{mk(0, {JMP_JEQ, 1'b0, CLS_JMP}, 0, 0, 16'h7FFF, 0, 0), 1,
                     res(ST_OK, 1, 17'h08000, 0)};
        plan[18] = '{mk(0, 8'h16, 0, 0, 3, 0, 0), 1, res(ST_ILLEGAL, 0, 0, 0)};
        plan[19] = '{mk(0, 8'he5, 0, 0, 3, 0, 0), 1, res(ST_ILLEGAL, 0, 0, 0)};
        plan[20] = '{mk(0, {JMP_JSGT, 1'b1, CLS_JMP}, 1, 3, 16'hFFFF, 0, 0), 0, none};
        plan[21] = '{mk(0, {ALU_MUL, 1'b1, CLS_ALU64}, 1, 3, 0, 0, 0), 0, none};
        plan[22] = '{mk(0, {4'hd, 1'b0, CLS_ALU32}, 0, 0, 0, 0, 0), 1, res(ST_ILLEGAL, 0, 0, 0)};
        plan[23] = '{mk(0, {ALU_RSH, 1'b1, CLS_ALU32}, 1, 10, 0, 0, 0), 0, none};

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Each phase programs new addresses while idle, then runs a batch of words.
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin
                    write_reg(CFG_CONTEXT, 64'hFFFF_FFFF_FFFF_FFFF);
                    write_reg(CFG_STACK, 64'hFFFF_FFFF_FFFF_FFFF);
                end
                1: begin
                    write_reg(CFG_CONTEXT, 64'd0);
                    write_reg(CFG_STACK, 64'd0);
                end
                default: begin
                    write_reg(CFG_CONTEXT, {$urandom, $urandom});
                    write_reg(CFG_STACK, {$urandom, $urandom});
                end
            endcase
            quiet = (ph == 3);
            if (ph == 0)
                foreach (plan[i])
                    send_word(plan[i].insn, plan[i].typed, plan[i].want);
            send_word(mk(1, 8'h00, 0, 0, 0, 0, 0), 0, none);
            for (int n = 0; n < 330; n++)
                send_word(rand_insn(), 0, none);
            drain();
        end

        if (errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

>>> filelist.f
+incdir+hdl
hdl/ebpf_pkg.sv
hdl/ebpf_muldiv.sv
hdl/ebpf_ctrl.sv
hdl/ebpf_dpath.sv
hdl/ebpf_alu_branch_execute_top.sv
tb/ebpf_alu_branch_execute_top_test.sv
